// ===== sv/cal_pkg.sv =====
package cal_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;
  localparam int FIELD_IDX_W = 5;
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > FIELD_IDX_W) ? CNT_W : FIELD_IDX_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_GET    = 2'd1,
    FN_SET    = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2
  } status_t;

  typedef struct packed {
    func_t                   func;
    logic [FIELD_IDX_W-1:0]  index;
    logic signed [31:0]      value;
  } req_beat_t;

  typedef struct packed {
    logic signed [31:0]  read_value;
    status_t             status;
    logic [CNT_W-1:0]    count;
  } rsp_beat_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/compacting_array_list.sv =====
// Fixed-capacity list of signed 32-bit words, held in a row of cells.
// Request channel (req_valid / req_stall / req): func, index, value.
// Response channel (rsp_valid / rsp_stall / rsp): read_value, status, count.
// Every request beat yields exactly one response beat, in order.
// The response is valid in the cycle after the request is accepted.
// One request per cycle while req_stall is low; push, set and remove update
// all cells together, each cell taking its right neighbor on a remove, and a
// get reads one cell through a 16-way select.
// The response register holds a finished beat; while it is valid and the
// receiver stalls, req_stall is high and no new request is taken. When the
// response is taken, the next request is accepted in that same cycle.
// cfg_we / cfg_data write capacity_limit (values above 16 act as 16); write
// it only while no request is in flight.
// Reset (rst, synchronous): count goes to zero, capacity_limit to 16, and the
// response register empties. Cell contents are not cleared; only entries
// below count are ever read.
module compacting_array_list (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  cal_pkg::req_beat_t    req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output cal_pkg::rsp_beat_t    rsp,
  input  logic                  cfg_we,
  input  logic [cal_pkg::CAP_W-1:0] cfg_data
);
  import cal_pkg::*;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CAP_W-1:0]   cap;
  logic [CNT_W-1:0]   cap_eff;
  logic               accept;
  logic               push_ok;
  logic               idx_ok;
  logic [CMP_W-1:0]   idx_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic signed [31:0] cell_data [DEPTH];
  cell_ctrl_t         ctrl [DEPTH];
  rsp_beat_t          rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign cap_eff = (cap > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap);
  assign idx_ext = CMP_W'(req.index);
  assign cnt_ext = CMP_W'(count);
  assign idx_ok  = idx_ext < cnt_ext;
  assign push_ok = count < cap_eff;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] POS = CMP_W'(i);
    logic signed [31:0] nbr;

    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    assign ctrl[i].load = accept &&
      ((req.func == FN_PUSH && push_ok && cnt_ext == POS) ||
       (req.func == FN_SET && idx_ok && idx_ext == POS));
    assign ctrl[i].shift = accept && req.func == FN_REMOVE && idx_ok &&
      POS >= idx_ext && (POS + CMP_W'(1)) < cnt_ext;

    cal_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl[i]),
      .value (req.value),
      .nbr   (nbr),
      .data  (cell_data[i])
    );
  end

  always_comb begin
    count_next          = count;
    rsp_next.read_value = '0;
    rsp_next.status     = ST_OK;
    case (req.func)
      FN_PUSH: begin
        if (push_ok) begin
          count_next = count + CNT_W'(1);
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      FN_GET: begin
        if (idx_ok) begin
          rsp_next.read_value = cell_data[req.index[IDX_W-1:0]];
        end else begin
          rsp_next.status     = ST_BADIDX;
          rsp_next.read_value = -32'sd1;
        end
      end
      FN_SET: begin
        if (!idx_ok) begin
          rsp_next.status = ST_BADIDX;
        end
      end
      FN_REMOVE: begin
        if (idx_ok) begin
          count_next = count - CNT_W'(1);
        end else begin
          rsp_next.status = ST_BADIDX;
        end
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
    rsp_next.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cap       <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload register: advance only on an accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("count exceeds depth");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count == count)
    else $error("response count differs from list count");

  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == FN_PUSH && push_ok) |=> count == $past(count) + CNT_W'(1))
    else $error("accepted push did not grow the list");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> rsp.read_value == 32'sd0)
    else $error("full response carries a nonzero word");

endmodule

// ===== sv/cal_cell.sv =====
module cal_cell (
  input  logic               clk,
  input  cal_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0] value,
  input  logic signed [31:0] nbr,
  output logic signed [31:0] data
);
  import cal_pkg::*;

  logic signed [31:0] data_next;

  // shift wins: a remove never loads in the same beat
  always_comb begin
    if (ctrl.shift) begin
      data_next = nbr;
    end else if (ctrl.load) begin
      data_next = value;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cal_pkg::*;

  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int STALL_PCT = 22;
  localparam int HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic signed [31:0] BAD_READ = -32'sd1;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_beat_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_beat_t rsp;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;

  // list mirror
  logic signed [31:0] list_words [DEPTH];
  int list_used = 0;
  logic [CAP_W-1:0] cap_limit = CAP_RESET;

  rsp_beat_t expected_rsp_q[$];
  bit steady = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int n_full = 0;
  int n_badidx = 0;
  int quiet_cycles = 0;

  compacting_array_list dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_beat_t list_apply(req_beat_t b);
    rsp_beat_t r;
    int lim;
    r.read_value = '0;
    r.status = ST_OK;
    lim = (int'(cap_limit) > DEPTH) ? DEPTH : int'(cap_limit);
    if (b.func == FN_PUSH) begin
      if (list_used >= lim) begin
        r.status = ST_FULL;
      end else begin
        list_words[list_used] = b.value;
        list_used++;
      end
    end else if (int'(b.index) >= list_used) begin
      r.status = ST_BADIDX;
      if (b.func == FN_GET) r.read_value = BAD_READ;
    end else begin
      case (b.func)
        FN_GET: r.read_value = list_words[b.index];
        FN_SET: list_words[b.index] = b.value;
        FN_REMOVE: begin
          // close the gap: every later word moves down one place
          for (int i = int'(b.index); i + 1 < list_used; i++)
            list_words[i] = list_words[i + 1];
          list_used--;
        end
        default: ;
      endcase
    end
    r.count = CNT_W'(list_used);
    return r;
  endfunction

  function automatic req_beat_t list_op(func_t f, int idx, logic signed [31:0] v);
    req_beat_t b;
    b.func = f;
    b.index = FIELD_IDX_W'(idx);
    b.value = v;
    return b;
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(19))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return BAD_READ;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_beat_t pick_op(int push_pct);
    func_t f;
    int r;
    int idx;
    r = $urandom_range(99);
    if (r < push_pct) f = FN_PUSH;
    else if (r < push_pct + (100 - push_pct) / 3) f = FN_GET;
    else if (r < push_pct + 2 * (100 - push_pct) / 3) f = FN_SET;
    else f = FN_REMOVE;
    // mostly in range, so that set and remove actually change the list
    if (list_used > 0 && $urandom_range(99) < 85) idx = $urandom_range(list_used - 1);
    else idx = $urandom_range(31);
    return list_op(f, idx, pick_word());
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_op(req_beat_t b);
    rsp_beat_t want;
    @(negedge clk);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= b;
    do @(posedge clk); while (!(req_valid && !req_stall));
    want = list_apply(b);
    if (want.status == ST_FULL) n_full++;
    if (want.status == ST_BADIDX) n_badidx++;
    expected_rsp_q.push_back(want);
    n_items++;
  endtask

  task automatic drain_list();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] lim);
    drain_list();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    cap_limit = lim;
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // response side: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= !steady && ($urandom_range(99) < STALL_PCT);
    end
  end

  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_results++;
      if (expected_rsp_q.size() == 0) begin
        $display("[%0t] response beat with nothing outstanding", $time);
        errors++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.read_value !== want.read_value)
          report_mismatch("read_value", rsp.read_value, want.read_value);
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.count !== want.count)
          report_mismatch("count", rsp.count, want.count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat moved in %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic test_empty_list();
    send_op(list_op(FN_GET, 0, 32'sd7));
    send_op(list_op(FN_REMOVE, 0, 32'sd0));
    send_op(list_op(FN_SET, 0, 32'sd9));
  endtask

  task automatic test_basic_ops();
    send_op(list_op(FN_PUSH, 0, WORD_MAX));
    send_op(list_op(FN_PUSH, 0, WORD_MIN));
    send_op(list_op(FN_PUSH, 31, '0));     // push ignores the index
    send_op(list_op(FN_GET, 1, '0));
    send_op(list_op(FN_GET, 2, '0));
    send_op(list_op(FN_GET, 3, '0));
    send_op(list_op(FN_GET, 31, '0));
    send_op(list_op(FN_SET, 1, BAD_READ));
    send_op(list_op(FN_SET, 20, WORD_MAX));
    send_op(list_op(FN_REMOVE, 0, '0));
    send_op(list_op(FN_GET, 0, '0));
    send_op(list_op(FN_REMOVE, 5, '0));
  endtask

  task automatic test_capacity_edges();
    set_capacity(CAP_W'(2));
    send_op(list_op(FN_PUSH, 0, 32'sd1));
    set_capacity('0);
    send_op(list_op(FN_PUSH, 0, 32'sd2));
    // limit below the count: entries stay, push is refused until removes
    set_capacity(CAP_W'(1));
    send_op(list_op(FN_PUSH, 0, 32'sd3));
    send_op(list_op(FN_REMOVE, 1, '0));
    send_op(list_op(FN_PUSH, 0, 32'sd4));
    send_op(list_op(FN_REMOVE, 0, '0));
    send_op(list_op(FN_PUSH, 0, 32'sh5555_5555));
    send_op(list_op(FN_PUSH, 0, 32'sh2aaa_aaaa));
    set_capacity(CAP_W'(31));
    send_op(list_op(FN_PUSH, 16, 32'sh1234_5678));
    send_op(list_op(FN_GET, 1, '0));
  endtask

  task automatic test_backpressure();
    drain_list();
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    repeat (20) send_op(pick_op(50));
  endtask

  task automatic test_drain_pause();
    repeat (10) send_op(pick_op(50));
    drain_list();
    repeat (10) send_op(pick_op(50));
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [PHASES];
    caps = '{CAP_W'(16), CAP_W'(31), CAP_W'(3), CAP_W'(1), '0, CAP_W'(16), CAP_W'(8),
             CAP_W'($urandom_range(31))};
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(caps[p]);
      steady = (p == 5);
      // alternate growing and shrinking phases so the list fills and empties
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_op(pick_op((p % 2 == 0) ? 65 : 30));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_basic_ops();
    test_capacity_edges();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    drain_list();
    repeat (3) @(posedge clk);
    $display("Ran %0d list operations (%0d responses checked) over %0d capacity settings;",
             n_items, n_results, n_cfg);
    $display("%0d pushes hit a full list and %0d operations used an out-of-range index.",
             n_full, n_badidx);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
